[design/oaht_pkg.sv]
package oaht_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int BYTE_W         = 8;
    localparam int KEY_W          = 64;
    localparam int HASH_W         = 32;
    localparam int SLOT_W         = 4;
    localparam int OP_W           = 2;
    localparam int ST_W           = 2;
    localparam int MOD_BITS       = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd0;
    localparam logic [ST_W-1:0] ST_USED    = 2'd1;
    localparam logic [ST_W-1:0] ST_DELETED = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] value_out;
        logic [SLOT_W-1:0] slot;
    } rsp_t;

endpackage

[design/oaht_front.sv]
module oaht_front #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF,
    localparam int AW        = $clog2(TABLE_SIZE),
    localparam int KW        = KEY_BYTES * oaht_pkg::BYTE_W,
    localparam int WW        = oaht_pkg::OP_W + oaht_pkg::BYTE_W + AW + KW
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  oaht_pkg::req_t       req,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 hold,
    output logic [WW-1:0]        work,
    output logic                 work_valid,
    input  logic                 work_ready
);

    localparam int RW        = AW + 1;
    localparam int MOD_STEPS = oaht_pkg::HASH_W / oaht_pkg::MOD_BITS;
    localparam int SW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_MOD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                     state_reg;
    logic [SW-1:0]                  step_reg;
    logic [oaht_pkg::OP_W-1:0]      op_reg;
    logic [oaht_pkg::BYTE_W-1:0]    value_reg;
    logic [KW-1:0]                  key_reg;
    logic [KEY_BYTES-1:0]           onehot_reg;
    logic [KEY_BYTES-1:0]           mask_reg;
    logic [oaht_pkg::HASH_W-1:0]    h_reg;
    logic [RW-1:0]                  r_reg;

    logic [oaht_pkg::BYTE_W-1:0]    c;
    logic                           hash_done;
    logic [oaht_pkg::HASH_W-1:0]    h_next;
    logic [RW-1:0]                  r_next;
    logic [KW-1:0]                  nk;
    logic                           accept;

    assign req_ready  = (state_reg == F_IDLE) && !hold;
    assign accept     = req_valid && req_ready;
    assign work_valid = (state_reg == F_PUSH);
    assign work       = {op_reg, value_reg, r_reg[AW-1:0], nk};

    always_comb
    begin
        c = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (onehot_reg[b])
            begin
                c = c | key_reg[b*oaht_pkg::BYTE_W +: oaht_pkg::BYTE_W];
            end
        end
    end

    assign hash_done = (onehot_reg == '0) || (c == '0);
    assign h_next = oaht_pkg::HASH_W'((h_reg + oaht_pkg::HASH_W'(c)) * oaht_pkg::HASH_W'(c));

    always_comb
    begin
        logic [RW-1:0] t;
        t = r_reg;
        for (int k = 0; k < oaht_pkg::MOD_BITS; k++)
        begin
            t = {t[RW-2:0], h_reg[oaht_pkg::HASH_W-1-k]};
            if (t >= RW'(TABLE_SIZE))
            begin
                t = t - RW'(TABLE_SIZE);
            end
        end
        r_next = t;
    end

    always_comb
    begin
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            nk[b*oaht_pkg::BYTE_W +: oaht_pkg::BYTE_W] =
                mask_reg[b] ? key_reg[b*oaht_pkg::BYTE_W +: oaht_pkg::BYTE_W] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_HASH;
                    end
                end
                F_HASH:
                begin
                    if (hash_done)
                    begin
                        state_reg <= F_MOD;
                        step_reg  <= '0;
                    end
                end
                F_MOD:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(MOD_STEPS - 1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (work_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.op;
            value_reg  <= req.value;
            key_reg    <= req.key[KW-1:0];
            onehot_reg <= KEY_BYTES'(1);
            mask_reg   <= '0;
            h_reg      <= '0;
            r_reg      <= '0;
        end
        else if (state_reg == F_HASH && !hash_done)
        begin
            mask_reg   <= mask_reg | onehot_reg;
            onehot_reg <= onehot_reg << 1;
            h_reg      <= h_next;
        end
        else if (state_reg == F_MOD)
        begin
            r_reg <= r_next;
            h_reg <= h_reg << oaht_pkg::MOD_BITS;
        end
    end

endmodule

[design/oaht_queue.sv]
module oaht_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = oaht_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] push_data,
    input  logic             push_valid,
    output logic             push_ready,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid,
    input  logic             pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/oaht_back.sv]
module oaht_back #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF,
    localparam int AW        = $clog2(TABLE_SIZE),
    localparam int KW        = KEY_BYTES * oaht_pkg::BYTE_W,
    localparam int WW        = oaht_pkg::OP_W + oaht_pkg::BYTE_W + AW + KW
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [WW-1:0]  work,
    input  logic           work_valid,
    output logic           work_ready,
    output oaht_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output logic           clearing
);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_PROBE = 2'd2;

    logic [oaht_pkg::ST_W-1:0]   status_mem [TABLE_SIZE];
    logic [KW-1:0]               key_mem    [TABLE_SIZE];
    logic [oaht_pkg::BYTE_W-1:0] value_mem  [TABLE_SIZE];

    logic [1:0]                  state_reg;
    logic [AW-1:0]               clr_reg;
    logic [AW-1:0]               cur_reg;
    logic [AW-1:0]               cnt_reg;
    logic                        rsp_valid_reg;
    oaht_pkg::rsp_t              rsp_reg;
    logic [oaht_pkg::OP_W-1:0]   op_reg;
    logic [KW-1:0]               key_reg;
    logic [oaht_pkg::BYTE_W-1:0] value_reg;

    logic [oaht_pkg::ST_W-1:0]   st_q;
    logic [KW-1:0]               key_q;
    logic [oaht_pkg::BYTE_W-1:0] val_q;

    logic [oaht_pkg::OP_W-1:0]   w_op;
    logic [oaht_pkg::BYTE_W-1:0] w_value;
    logic [AW-1:0]               w_home;
    logic [KW-1:0]               w_key;

    logic                        accept;
    logic                        w_op_ok;
    logic                        is_ins;
    logic                        hit;
    logic                        miss;
    logic                        last;
    logic [AW-1:0]               nxt;
    logic [AW-1:0]               rd_addr;
    logic                        st_we;
    logic [AW-1:0]               st_addr;
    logic [oaht_pkg::ST_W-1:0]   st_data;
    logic                        kv_we;

    assign {w_op, w_value, w_home, w_key} = work;

    assign clearing   = (state_reg == B_CLEAR);
    assign work_ready = (state_reg == B_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept     = work_valid && work_ready;
    assign w_op_ok    = (w_op == oaht_pkg::OP_INSERT) || (w_op == oaht_pkg::OP_LOOKUP)
                        || (w_op == oaht_pkg::OP_DELETE);

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign is_ins = (op_reg == oaht_pkg::OP_INSERT);
    assign hit    = is_ins ? (st_q != oaht_pkg::ST_USED)
                           : ((st_q == oaht_pkg::ST_USED) && (key_q == key_reg));
    assign miss   = !is_ins && (st_q == oaht_pkg::ST_EMPTY);
    assign last   = (cnt_reg == AW'(TABLE_SIZE - 1));
    assign nxt    = (cur_reg == AW'(TABLE_SIZE - 1)) ? '0 : cur_reg + 1'b1;
    assign rd_addr = (state_reg == B_PROBE) ? nxt : w_home;

    always_comb
    begin
        st_we   = 1'b0;
        st_addr = cur_reg;
        st_data = oaht_pkg::ST_USED;
        kv_we   = 1'b0;
        if (state_reg == B_CLEAR)
        begin
            st_we   = 1'b1;
            st_addr = clr_reg;
            st_data = oaht_pkg::ST_EMPTY;
        end
        else if (state_reg == B_PROBE && hit)
        begin
            if (is_ins)
            begin
                st_we = 1'b1;
                kv_we = 1'b1;
            end
            else if (op_reg == oaht_pkg::OP_DELETE)
            begin
                st_we   = 1'b1;
                st_data = oaht_pkg::ST_DELETED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[st_addr] <= st_data;
        end
        if (kv_we)
        begin
            key_mem[cur_reg]   <= key_reg;
            value_mem[cur_reg] <= value_reg;
        end
        st_q  <= status_mem[rd_addr];
        key_q <= key_mem[rd_addr];
        val_q <= value_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && !(accept && !w_op_ok))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(TABLE_SIZE - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (accept)
                    begin
                        if (w_op_ok)
                        begin
                            state_reg <= B_PROBE;
                        end
                        else
                        begin
                            rsp_valid_reg <= 1'b1;
                        end
                    end
                end
                B_PROBE:
                begin
                    if (hit || miss || last)
                    begin
                        state_reg     <= B_IDLE;
                        rsp_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= w_op;
            key_reg   <= w_key;
            value_reg <= w_value;
            cur_reg   <= w_home;
            cnt_reg   <= '0;
            rsp_reg   <= '0;
        end
        else if (state_reg == B_PROBE)
        begin
            if (hit)
            begin
                rsp_reg.ok        <= 1'b1;
                rsp_reg.value_out <= is_ins ? '0 : val_q;
                rsp_reg.slot      <= oaht_pkg::SLOT_W'(cur_reg);
            end
            else if (!miss && !last)
            begin
                cur_reg <= nxt;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

[design/open_addressing_hash_table.sv]
// Hash table with linear probing and deleted-slot markers. Each request inserts, looks up
// or deletes a key of up to KEY_BYTES bytes (ending at the first zero byte); one response
// follows every request. The front end hashes one key byte per cycle, then reduces the
// 32-bit hash to a home slot four bits per cycle, and hands the request over a two-entry
// queue to the probe engine; it takes the next request only once the last is handed over.
// The probe engine reads one slot per cycle from its slot memories (one read port, one
// write port), starting with a launch of the home read and visiting at most TABLE_SIZE
// slots. The two halves overlap, so throughput is set by the slower of the two for the
// request mix. After reset the slot status memory is swept to empty; in_ready stays low
// until the sweep is done.
module open_addressing_hash_table #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  oaht_pkg::req_t in_data,
    input  logic           in_valid,
    output logic           in_ready,
    output oaht_pkg::rsp_t out_data,
    output logic           out_valid,
    input  logic           out_ready
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int KW = KEY_BYTES * oaht_pkg::BYTE_W;
    localparam int WW = oaht_pkg::OP_W + oaht_pkg::BYTE_W + AW + KW;

    logic [WW-1:0] f_work;
    logic          f_valid;
    logic          f_ready;
    logic [WW-1:0] q_work;
    logic          q_valid;
    logic          q_ready;
    logic          clearing;

    oaht_front #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (in_data),
        .req_valid  (in_valid),
        .req_ready  (in_ready),
        .hold       (clearing),
        .work       (f_work),
        .work_valid (f_valid),
        .work_ready (f_ready)
    );

    oaht_queue #(
        .WIDTH (WW),
        .DEPTH (oaht_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (f_work),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_data   (q_work),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    oaht_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (q_work),
        .work_valid (q_valid),
        .work_ready (q_ready),
        .rsp        (out_data),
        .rsp_valid  (out_valid),
        .rsp_ready  (out_ready),
        .clearing   (clearing)
    );

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.value_out == '0 && out_data.slot == '0)
        else $error("failed response carries nonzero payload");

    a_no_req_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("request accepted during status sweep");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |-> !out_valid || out_ready)
        else $error("probe started with response slot occupied");

endmodule

[tb/sv/open_addressing_hash_table_tb.sv]
`timescale 1ns / 1ps

module open_addressing_hash_table_tb;

    localparam int N_SLOTS    = oaht_pkg::TABLE_SIZE_DEF;
    localparam int N_KEYBYTES = oaht_pkg::KEY_BYTES_DEF;
    localparam int POOL_N     = 12;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_LEN   = 300;
    localparam logic [oaht_pkg::OP_W-1:0] OP_UNDEF = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    oaht_pkg::req_t in_data;
    logic in_valid;
    logic in_ready;
    oaht_pkg::rsp_t out_data;
    logic out_valid;
    logic out_ready;

    logic [oaht_pkg::ST_W-1:0]   slot_state [N_SLOTS];
    logic [oaht_pkg::KEY_W-1:0]  slot_key_m [N_SLOTS];
    logic [oaht_pkg::BYTE_W-1:0] slot_val_m [N_SLOTS];

    oaht_pkg::rsp_t pending_rsp [$];
    oaht_pkg::rsp_t want_rsp;
    logic [oaht_pkg::KEY_W-1:0] key_pool [POOL_N];
    int   errors = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    bit   calm = 1'b0;

    open_addressing_hash_table #(
        .TABLE_SIZE(N_SLOTS),
        .KEY_BYTES (N_KEYBYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_data (out_data),
        .out_valid(out_valid),
        .out_ready(out_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [oaht_pkg::KEY_W-1:0] eff_key(
        input logic [oaht_pkg::KEY_W-1:0] raw, output int home);
        logic [oaht_pkg::HASH_W-1:0] h;
        logic [oaht_pkg::KEY_W-1:0]  nk;
        logic [oaht_pkg::HASH_W-1:0] c;
        bit                          stop;
        h    = '0;
        nk   = '0;
        stop = 1'b0;
        for (int i = 0; i < N_KEYBYTES; i++)
        begin
            c = oaht_pkg::HASH_W'(raw[8*i +: 8]);
            if (c == 0)
                stop = 1'b1;
            if (!stop)
            begin
                nk[8*i +: 8] = c[7:0];
                h = (h + c) * c;
            end
        end
        home = int'(h % N_SLOTS);
        return nk;
    endfunction

    function automatic oaht_pkg::rsp_t table_apply(input oaht_pkg::req_t r);
        oaht_pkg::rsp_t             res;
        logic [oaht_pkg::KEY_W-1:0] nk;
        int                         home;
        int                         s;
        bit                         done;
        res  = '0;
        done = 1'b0;
        nk   = eff_key(r.key, home);
        for (int i = 0; i < N_SLOTS; i++)
        begin
            s = (home + i) % N_SLOTS;
            if (done)
                continue;
            if (r.op == oaht_pkg::OP_INSERT)
            begin
                if (slot_state[s] != oaht_pkg::ST_USED)
                begin
                    slot_state[s] = oaht_pkg::ST_USED;
                    slot_key_m[s] = nk;
                    slot_val_m[s] = r.value;
                    res.ok   = 1'b1;
                    res.slot = oaht_pkg::SLOT_W'(s);
                    done     = 1'b1;
                end
            end
            else if (r.op == oaht_pkg::OP_LOOKUP || r.op == oaht_pkg::OP_DELETE)
            begin
                if (slot_state[s] == oaht_pkg::ST_EMPTY)
                    done = 1'b1;
                else if (slot_state[s] == oaht_pkg::ST_USED && slot_key_m[s] == nk)
                begin
                    res.ok        = 1'b1;
                    res.value_out = slot_val_m[s];
                    res.slot      = oaht_pkg::SLOT_W'(s);
                    if (r.op == oaht_pkg::OP_DELETE)
                        slot_state[s] = oaht_pkg::ST_DELETED;
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic send_req(input logic [oaht_pkg::OP_W-1:0] op,
                            input logic [oaht_pkg::KEY_W-1:0] k,
                            input logic [oaht_pkg::BYTE_W-1:0] v);
        oaht_pkg::req_t r;
        r.op    = op;
        r.key   = k;
        r.value = v;
        if (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        in_data  <= r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_rsp.push_back(table_apply(r));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [oaht_pkg::KEY_W-1:0] random_word_key();
        logic [oaht_pkg::KEY_W-1:0] k;
        int                         len;
        k   = '0;
        len = $urandom_range(N_KEYBYTES, 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(1))
                k[8*i +: 8] = 8'($urandom_range(8'h7A, 8'h61));
            else
                k[8*i +: 8] = 8'($urandom_range(255, 1));
        end
        return k;
    endfunction

    // on a coin flip, fill the bytes after the terminating zero with garbage
    function automatic logic [oaht_pkg::KEY_W-1:0] add_tail(
        input logic [oaht_pkg::KEY_W-1:0] k);
        logic [oaht_pkg::KEY_W-1:0] junk;
        int                         len;
        len = 0;
        while (len < 8 && k[8*len +: 8] != 8'h00)
            len++;
        junk = {$urandom, $urandom};
        if (len < 7 && $urandom_range(1))
            k = k | (junk << (8 * (len + 1)));
        return k;
    endfunction

    task automatic test_directed;
        send_req(oaht_pkg::OP_LOOKUP, 64'h0000_0000_0074_6163, 8'h00);
        send_req(oaht_pkg::OP_DELETE, 64'h0000_0000_0074_6163, 8'h00);
        send_req(oaht_pkg::OP_INSERT, 64'h0000_0000_0000_0000, 8'h00);
        send_req(oaht_pkg::OP_LOOKUP, 64'hA5A5_A5A5_A5A5_A500, 8'hFF);
        send_req(oaht_pkg::OP_INSERT, 64'h0000_0000_0074_6163, 8'hFF);
        send_req(oaht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h5A);
        send_req(oaht_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        send_req(oaht_pkg::OP_INSERT, 64'hDEAD_BEEF_0000_4241, 8'h11);
        send_req(oaht_pkg::OP_LOOKUP, 64'h1234_5678_9A00_4241, 8'h00);
        send_req(oaht_pkg::OP_INSERT, 64'h0000_0000_0074_6163, 8'h22);
        send_req(oaht_pkg::OP_LOOKUP, 64'h0000_0000_0074_6163, 8'h00);
        send_req(oaht_pkg::OP_DELETE, 64'h0000_0000_0074_6163, 8'h00);
        send_req(oaht_pkg::OP_LOOKUP, 64'h0000_0000_0074_6163, 8'h00);
        send_req(oaht_pkg::OP_INSERT, 64'h0000_0000_0067_6F64, 8'h33);
        send_req(OP_UNDEF,            64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_req(oaht_pkg::OP_DELETE, 64'h0000_0000_0000_0000, 8'h00);
        send_req(oaht_pkg::OP_LOOKUP, 64'h0000_0000_0000_0000, 8'h00);
        send_req(oaht_pkg::OP_INSERT, 64'h0102_0304_0506_0708, 8'h80);
        send_req(oaht_pkg::OP_LOOKUP, 64'h0102_0304_0506_0708, 8'h00);
        send_req(oaht_pkg::OP_LOOKUP, 64'h0202_0304_0506_0708, 8'h00);
        send_req(oaht_pkg::OP_DELETE, 64'h0102_0304_0506_0708, 8'h00);
        send_req(oaht_pkg::OP_LOOKUP, 64'h8081_8283_8485_8687, 8'h00);
        drain();
    endtask

    task automatic test_full_table;
        for (int i = 0; i < N_SLOTS + 2; i++)
            send_req(oaht_pkg::OP_INSERT, oaht_pkg::KEY_W'(16'h5A41 + i), 8'(i + 1));
        send_req(oaht_pkg::OP_LOOKUP, 64'h0000_0000_0000_7A7A, 8'h00);
        for (int i = 0; i < N_SLOTS + 2; i++)
            send_req(oaht_pkg::OP_DELETE, oaht_pkg::KEY_W'(16'h5A41 + i), 8'h00);
        send_req(oaht_pkg::OP_LOOKUP, 64'h0000_0000_0000_7A7A, 8'h00);
        send_req(oaht_pkg::OP_INSERT, 64'h0000_0000_0000_7A7A, 8'h44);
        send_req(oaht_pkg::OP_LOOKUP, 64'h0000_0000_0000_7A7A, 8'h00);
        drain();
    endtask

    task automatic test_backpressure;
        hold_left = HOLD_LEN;
        for (int i = 0; i < 12; i++)
            send_req(oaht_pkg::OP_LOOKUP, random_word_key(), 8'($urandom_range(255)));
        drain();
    endtask

    task automatic test_random;
        logic [oaht_pkg::OP_W-1:0]  op;
        logic [oaht_pkg::KEY_W-1:0] k;
        int                         pick;
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = random_word_key();
        for (int n = 0; n < 1900; n++)
        begin
            calm = (n >= 800 && n < 1100);
            pick = $urandom_range(99);
            if (pick < 35)
                op = oaht_pkg::OP_INSERT;
            else if (pick < 65)
                op = oaht_pkg::OP_LOOKUP;
            else if (pick < 97)
                op = oaht_pkg::OP_DELETE;
            else
                op = OP_UNDEF;
            if ($urandom_range(49) == 0)
                key_pool[$urandom_range(POOL_N - 1)] = random_word_key();
            if ($urandom_range(9) == 0)
                k = {$urandom, $urandom};
            else
                k = add_tail(key_pool[$urandom_range(POOL_N - 1)]);
            send_req(op, k, 8'($urandom_range(255)));
        end
        calm = 1'b0;
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < N_SLOTS; i++)
            slot_state[i] = oaht_pkg::ST_EMPTY;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("response with no request pending", 64'(out_data), 0);
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (out_data.ok !== want_rsp.ok)
                    report_mismatch("ok", 64'(out_data.ok), 64'(want_rsp.ok));
                if (out_data.value_out !== want_rsp.value_out)
                    report_mismatch("value_out", 64'(out_data.value_out),
                                    64'(want_rsp.value_out));
                if (out_data.slot !== want_rsp.slot)
                    report_mismatch("slot", 64'(out_data.slot), 64'(want_rsp.slot));
            end
        end
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
